@@ rtl/tpa_pkg.sv @@
// ----------------------------------------------------------------------------
// tpa_pkg
// shared types and constants of the triangle primitive assembler
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int CORNER_BITS = 32;
  localparam int MODE_BITS   = 3;

  localparam logic [MODE_BITS-1:0] MODE_TRIANGLES  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_STRIP      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_FAN        = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_QUADS      = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_QUAD_STRIP = 3'd4;

  // entries written into the result queue in one cycle
  typedef struct packed {
    logic first;
    logic second;
  } tpa_push_t;

endpackage

@@ rtl/tpa_assemble.sv @@
// ----------------------------------------------------------------------------
// tpa_assemble
// input register, vertex history and per-mode triangle assembly
// ----------------------------------------------------------------------------
module tpa_assemble #(
  parameter int INDEX_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpa_pkg::MODE_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [INDEX_BITS-1:0]         in_index,
  input  logic                          in_eob,
  input  logic                          room,
  output tpa_pkg::tpa_push_t            push,
  output logic [3*INDEX_BITS:0]         entry0,
  output logic [3*INDEX_BITS:0]         entry1
);
  import tpa_pkg::*;

  logic [MODE_BITS-1:0]  primitive_mode;
  logic                  stage_valid;
  logic [INDEX_BITS-1:0] stage_index;
  logic                  stage_eob;
  logic [INDEX_BITS-1:0] history_oldest;
  logic [INDEX_BITS-1:0] history_middle;
  logic [INDEX_BITS-1:0] history_newest;
  logic [INDEX_BITS-1:0] fan_anchor;
  logic [1:0]            batch_phase;
  logic [1:0]            batch_phase_next;
  logic [1:0]            warmup_count;
  logic                  strip_parity;
  logic                  fire;
  logic                  emit_one;
  logic                  emit_two;
  logic [INDEX_BITS-1:0] a0, b0, c0, a1, b1, c1;

  assign fire     = stage_valid && room;
  assign in_ready = !stage_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      primitive_mode <= MODE_TRIANGLES;
    end else if (cfg_we) begin
      primitive_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_index <= in_index;
      stage_eob   <= in_eob;
    end
  end

  always_comb begin
    emit_one = 1'b0;
    emit_two = 1'b0;
    a0 = history_middle;
    b0 = history_newest;
    c0 = stage_index;
    a1 = history_oldest;
    b1 = history_newest;
    c1 = stage_index;
    case (primitive_mode)
      MODE_TRIANGLES: begin
        emit_one = (batch_phase == 2'd2);
      end
      MODE_STRIP: begin
        emit_one = warmup_count[1];
        if (strip_parity) begin
          a0 = history_newest;
          b0 = history_middle;
        end
      end
      MODE_FAN: begin
        emit_one = warmup_count[1];
        a0 = fan_anchor;
      end
      MODE_QUADS: begin
        emit_two = (batch_phase == 2'd3);
        a0 = history_oldest;
        b0 = history_middle;
        c0 = history_newest;
      end
      MODE_QUAD_STRIP: begin
        emit_two = (warmup_count == 2'd3) && strip_parity;
        a0 = history_oldest;
        b0 = history_middle;
        c0 = history_newest;
        a1 = history_middle;
        b1 = stage_index;
        c1 = history_newest;
      end
      default: begin
        emit_one = 1'b0;
      end
    endcase
  end

  assign push.first  = fire && (emit_one || emit_two);
  assign push.second = fire && emit_two;
  assign entry0 = {emit_one, c0, b0, a0};
  assign entry1 = {1'b1, c1, b1, a1};

  always_comb begin
    if (primitive_mode == MODE_TRIANGLES) begin
      batch_phase_next = (batch_phase >= 2'd2) ? 2'd0 : batch_phase + 2'd1;
    end else begin
      batch_phase_next = batch_phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_phase  <= 2'd0;
      warmup_count <= 2'd0;
      strip_parity <= 1'b0;
    end else if (fire) begin
      if (stage_eob) begin
        batch_phase  <= 2'd0;
        warmup_count <= 2'd0;
        strip_parity <= 1'b0;
      end else begin
        batch_phase  <= batch_phase_next;
        warmup_count <= (warmup_count == 2'd3) ? 2'd3 : warmup_count + 2'd1;
        strip_parity <= !strip_parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_oldest <= '0;
      history_middle <= '0;
      history_newest <= '0;
      fan_anchor     <= '0;
    end else if (fire) begin
      history_oldest <= history_middle;
      history_middle <= history_newest;
      history_newest <= stage_index;
      if (warmup_count == 2'd0) begin
        fan_anchor <= stage_index;
      end
    end
  end

endmodule

@@ rtl/tpa_tri_queue.sv @@
// ----------------------------------------------------------------------------
// tpa_tri_queue
// four-entry result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module tpa_tri_queue #(
  parameter int INDEX_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tpa_pkg::tpa_push_t    push,
  input  logic [3*INDEX_BITS:0] entry0,
  input  logic [3*INDEX_BITS:0] entry1,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3*INDEX_BITS:0] out_entry
);
  import tpa_pkg::*;

  localparam int DEPTH = 4;

  logic [3*INDEX_BITS:0] mem [DEPTH];
  logic [1:0]            wr_ptr;
  logic [1:0]            rd_ptr;
  logic [2:0]            count;
  logic [1:0]            push_n;
  logic                  pop;

  assign push_n    = {1'b0, push.first} + {1'b0, push.second};
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign room      = (count <= 3'd2);
  assign out_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= entry0;
    end
    if (push.second) begin
      mem[wr_ptr + 2'd1] <= entry1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule

@@ rtl/triangle_primitive_assembler_top.sv @@
// ----------------------------------------------------------------------------
// triangle_primitive_assembler_top
// assembles a vertex index stream into triangles by primitive mode
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one vertex per transaction: tdata = vertex_index,
//   tlast = end_of_batch. m_axis carries one triangle per transaction:
//   tdata = corner_a, corner_b, corner_c (32 bits each, lowest first),
//   tlast = last_of_run (final triangle caused by one input vertex).
//   cfg_we / cfg_wdata write primitive_mode (0 triangles, 1 strip, 2 fan,
//   3 quads, 4 quad strip); write only while the block is idle.
//   m_tvalid for the first triangle of a vertex rises once the vertex has
//   passed the input register and been written into the result queue.
//   the input takes one vertex per cycle while the queue has room; each vertex
//   yields zero, one or two triangles, and the output drains one triangle
//   per cycle, so a two-triangle vertex costs an extra output beat.
//   an input register feeds the assembly logic, which writes a four-entry
//   result queue; the input register advances while the queue holds at most
//   two triangles, so a stalled receiver stops s_tready once it holds three or four.
//   reset clears the mode to triangles, the vertex history and the queue.
// ----------------------------------------------------------------------------
module triangle_primitive_assembler_top #(
  parameter int INDEX_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpa_pkg::MODE_BITS-1:0] cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // vertex_index
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [95:0]                   m_tdata,   // corner_a, corner_b, corner_c
  output logic                          m_tlast
);
  import tpa_pkg::*;

  tpa_push_t             push;
  logic [3*INDEX_BITS:0] entry0;
  logic [3*INDEX_BITS:0] entry1;
  logic [3*INDEX_BITS:0] out_entry;
  logic                  room;

  tpa_assemble #(
    .INDEX_BITS(INDEX_BITS)
  ) u_assemble (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_index (s_tdata[INDEX_BITS-1:0]),
    .in_eob   (s_tlast),
    .room     (room),
    .push     (push),
    .entry0   (entry0),
    .entry1   (entry1)
  );

  tpa_tri_queue #(
    .INDEX_BITS(INDEX_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry0   (entry0),
    .entry1   (entry1),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_entry(out_entry)
  );

  assign m_tdata = {CORNER_BITS'(out_entry[2*INDEX_BITS +: INDEX_BITS]),
                    CORNER_BITS'(out_entry[INDEX_BITS +: INDEX_BITS]),
                    CORNER_BITS'(out_entry[0 +: INDEX_BITS])};
  assign m_tlast = out_entry[3*INDEX_BITS];

endmodule
